/* rtl/core/plp_pkg.sv */
// ----------------------------------------------------------------------------
// plp_pkg
// Shared types, constants and saturating fixed-point helpers for the
// leapfrog particle push pipeline.
// ----------------------------------------------------------------------------
package plp_pkg;

	localparam int QW        = 32;           // signed Q16.16 word
	localparam int FracBits  = 16;
	localparam int ProdW     = 2 * QW;       // full product / extended sum
	localparam int BoxW      = 31;
	localparam int TsW       = 31;
	localparam int DrawW     = 16;
	localparam int ModeW     = 2;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 32;
	localparam int Axes      = 3;

	// remainder bits resolved per divider stage
	localparam int DivBitsPerStage = 2;

	localparam logic [BoxW-1:0] BoxReset      = BoxW'(65536);
	localparam logic [TsW-1:0]  TimeStepReset = TsW'(65536);

	typedef logic signed [QW-1:0] q_t;

	typedef enum logic [CfgIdxW-1:0] {
		RegHalfAccel  = 3'd0,
		RegTimeStep   = 3'd1,
		RegBoxX       = 3'd2,
		RegBoxY       = 3'd3,
		RegBoxZ       = 3'd4,
		RegBoundMode  = 3'd5,
		RegScatterThr = 3'd6
	} cfg_reg_t;

	typedef enum logic [ModeW-1:0] {
		BoundFree     = 2'd0,
		BoundPeriodic = 2'd1,
		BoundNone     = 2'd2
	} bound_mode_t;

	typedef enum logic [1:0] {
		OutKept    = 2'd0,
		OutRemoved = 2'd1,
		OutEmpty   = 2'd2
	} outcome_t;

	typedef struct packed {
		q_t                      half_accel;
		logic [TsW-1:0]          time_step;
		logic [Axes-1:0][BoxW-1:0] box;
		bound_mode_t             mode;
		logic [DrawW-1:0]        scatter_thr;
	} cfg_t;

	typedef struct packed {
		logic [Axes-1:0][QW-1:0] pos;
		logic [Axes-1:0][QW-1:0] vel;
		logic                    empty;
		logic [DrawW-1:0]        draw;
	} item_t;

	typedef struct packed {
		logic [Axes-1:0][QW-1:0] pos;
		logic [Axes-1:0][QW-1:0] vel;
		outcome_t                outcome;
		logic                    scatter;
		logic                    wrap;
	} res_t;

	// clamp a wide signed value into the q range
	function automatic q_t sat_q(input logic signed [ProdW-1:0] v);
		logic hi_same;
		hi_same = (v[ProdW-1:QW-1] == '0) || (v[ProdW-1:QW-1] == '1);
		if (hi_same) begin
			return v[QW-1:0];
		end else if (v[ProdW-1]) begin
			return {1'b1, {(QW-1){1'b0}}};
		end else begin
			return {1'b0, {(QW-1){1'b1}}};
		end
	endfunction

	function automatic q_t q_add(input q_t a, input q_t b);
		logic signed [ProdW-1:0] s;
		s = ProdW'(a) + ProdW'(b);
		return sat_q(s);
	endfunction

	// floor shift of a raw product back to Q16.16, saturated
	function automatic q_t q_scale(input logic signed [ProdW-1:0] p);
		return sat_q(p >>> FracBits);
	endfunction

endpackage

/* rtl/core/plp_if.sv */
// ----------------------------------------------------------------------------
// plp interfaces
// Particle request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface plp_particle_if import plp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [QW-1:0]    pos_x;
	logic [QW-1:0]    pos_y;
	logic [QW-1:0]    pos_z;
	logic [QW-1:0]    vel_x;
	logic [QW-1:0]    vel_y;
	logic [QW-1:0]    vel_z;
	logic [QW-1:0]    field_x;
	logic [QW-1:0]    field_y;
	logic [QW-1:0]    field_z;
	logic [DrawW-1:0] random_draw;
	logic             slot_empty;

	modport source (
		output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		output field_x, field_y, field_z, random_draw, slot_empty,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		input  field_x, field_y, field_z, random_draw, slot_empty,
		output ready
	);
endinterface

interface plp_result_if import plp_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [QW-1:0] new_x;
	logic [QW-1:0] new_y;
	logic [QW-1:0] new_z;
	logic [QW-1:0] new_vx;
	logic [QW-1:0] new_vy;
	logic [QW-1:0] new_vz;
	logic [1:0]    outcome;
	logic          scatter_request;

	modport source (
		output valid, new_x, new_y, new_z, new_vx, new_vy, new_vz,
		output outcome, scatter_request,
		input  ready
	);
	modport sink (
		input  valid, new_x, new_y, new_z, new_vx, new_vy, new_vz,
		input  outcome, scatter_request,
		output ready
	);
endinterface

interface plp_cfg_if import plp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/plp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// plp_cfg_regs
// Register file for the push parameters, written through the config channel.
// ----------------------------------------------------------------------------
module plp_cfg_regs import plp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	plp_cfg_if.sink cfg,
	output cfg_t    regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.half_accel  <= '0;
			regs_q.time_step   <= TimeStepReset;
			regs_q.box         <= {Axes{BoxReset}};
			regs_q.mode        <= BoundFree;
			regs_q.scatter_thr <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				RegHalfAccel:  regs_q.half_accel  <= cfg.data;
				RegTimeStep:   regs_q.time_step   <= cfg.data[TsW-1:0];
				RegBoxX:       regs_q.box[0]      <= cfg.data[BoxW-1:0];
				RegBoxY:       regs_q.box[1]      <= cfg.data[BoxW-1:0];
				RegBoxZ:       regs_q.box[2]      <= cfg.data[BoxW-1:0];
				RegBoundMode:  regs_q.mode        <= bound_mode_t'(cfg.data[ModeW-1:0]);
				RegScatterThr: regs_q.scatter_thr <= cfg.data[DrawW-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/plp_kick.sv */
// ----------------------------------------------------------------------------
// plp_kick
// Velocity update: field times factor, then two saturating half kicks.
// Three register stages.
// ----------------------------------------------------------------------------
module plp_kick import plp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  q_t   half_accel,
	input  logic in_valid,
	input  item_t in_item,
	input  logic [Axes-1:0][QW-1:0] field,
	output logic  out_valid,
	output item_t out_item
);

	logic                       valid_s1, valid_s2, valid_s3;
	item_t                      item_s1, item_s2, item_s3;
	logic [Axes-1:0][ProdW-1:0] prod_s1;
	logic [Axes-1:0][QW-1:0]    acc_s2, vel_s2;

	logic [Axes-1:0][ProdW-1:0] prod_d;
	logic [Axes-1:0][QW-1:0]    acc_d, vel1_d;
	item_t                      item3_d;

	always_comb begin
		for (int a = 0; a < Axes; a++) begin
			prod_d[a] = $signed(field[a]) * $signed(half_accel);
		end
	end

	always_comb begin
		for (int a = 0; a < Axes; a++) begin
			acc_d[a]  = q_scale($signed(prod_s1[a]));
			vel1_d[a] = q_add($signed(item_s1.vel[a]), $signed(acc_d[a]));
		end
	end

	// empty slots keep their original velocity
	always_comb begin
		item3_d = item_s2;
		if (!item_s2.empty) begin
			for (int a = 0; a < Axes; a++) begin
				item3_d.vel[a] = q_add($signed(vel_s2[a]), $signed(acc_s2[a]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			prod_s1 <= prod_d;
			item_s2 <= item_s1;
			acc_s2  <= acc_d;
			vel_s2  <= vel1_d;
			item_s3 <= item3_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

/* rtl/core/plp_drift.sv */
// ----------------------------------------------------------------------------
// plp_drift
// Position step v * dt, box test, outcome and scatter decision.
// Two register stages.
// ----------------------------------------------------------------------------
module plp_drift import plp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  cfg_t regs,
	input  logic in_valid,
	input  item_t in_item,
	output logic out_valid,
	output res_t out_res
);

	logic                       valid_s4, valid_s5;
	item_t                      item_s4;
	logic [Axes-1:0][ProdW-1:0] prod_s4;
	res_t                       res_s5;

	logic [Axes-1:0][ProdW-1:0] prod_d;
	logic signed [QW-1:0]       ts_q;
	res_t                       res_d;
	logic [Axes-1:0]            out_ax;
	logic                       outside;

	assign ts_q = {1'b0, regs.time_step};

	always_comb begin
		for (int a = 0; a < Axes; a++) begin
			prod_d[a] = $signed(in_item.vel[a]) * ts_q;
		end
	end

	always_comb begin
		res_d.vel     = item_s4.vel;
		res_d.pos     = item_s4.pos;
		out_ax        = '0;
		for (int a = 0; a < Axes; a++) begin
			if (!item_s4.empty) begin
				res_d.pos[a] = q_add($signed(item_s4.pos[a]), q_scale($signed(prod_s4[a])));
			end
			// a coordinate equal to the limit counts as inside
			out_ax[a] = res_d.pos[a][QW-1] ||
				($signed(res_d.pos[a]) > $signed({1'b0, regs.box[a]}));
		end
		outside       = (|out_ax) && !item_s4.empty;
		res_d.scatter = !item_s4.empty && (item_s4.draw < regs.scatter_thr);
		res_d.wrap    = outside && (regs.mode == BoundPeriodic);
		if (item_s4.empty) begin
			res_d.outcome = OutEmpty;
		end else if (outside && (regs.mode == BoundFree)) begin
			res_d.outcome = OutRemoved;
		end else begin
			res_d.outcome = OutKept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4 <= in_item;
			prod_s4 <= prod_d;
			res_s5  <= res_d;
		end
	end

	assign out_valid = valid_s5;
	assign out_res   = res_s5;

endmodule

/* rtl/core/plp_wrap.sv */
// ----------------------------------------------------------------------------
// plp_wrap
// Periodic wrap: pipelined restoring remainder per axis, then the sign
// correction that gives a non-negative remainder.
// ----------------------------------------------------------------------------
module plp_wrap import plp_pkg::*; #(
	parameter int DIV_BITS = DivBitsPerStage
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [Axes-1:0][BoxW-1:0] box,
	input  logic in_valid,
	input  res_t in_res,
	output logic out_valid,
	output res_t out_res
);

	localparam int Stages = (BoxW + DIV_BITS - 1) / DIV_BITS;

	logic [Axes-1:0][BoxW-1:0] rem_s [Stages];
	logic [Axes-1:0][BoxW-1:0] dvd_s [Stages];
	logic [Axes-1:0]           neg_s [Stages];
	logic                      valid_s [Stages];
	res_t                      res_s [Stages];

	logic [Axes-1:0][BoxW-1:0] dvd_first;
	logic [Axes-1:0]           neg_first;

	// x mod b for negative x is b - 1 - ((-x - 1) mod b), and -x - 1 is ~x
	always_comb begin
		for (int a = 0; a < Axes; a++) begin
			neg_first[a] = in_res.pos[a][QW-1];
			dvd_first[a] = neg_first[a] ? ~in_res.pos[a][BoxW-1:0] : in_res.pos[a][BoxW-1:0];
		end
	end

	for (genvar k = 0; k < Stages; k++) begin : g_div
		logic [Axes-1:0][BoxW-1:0] rem_d, dvd_d, rem_nx, dvd_nx;
		logic [Axes-1:0]           neg_d;
		logic                      valid_d;
		res_t                      res_d;

		if (k == 0) begin : g_first
			assign rem_d   = '0;
			assign dvd_d   = dvd_first;
			assign neg_d   = neg_first;
			assign valid_d = in_valid;
			assign res_d   = in_res;
		end else begin : g_next
			assign rem_d   = rem_s[k-1];
			assign dvd_d   = dvd_s[k-1];
			assign neg_d   = neg_s[k-1];
			assign valid_d = valid_s[k-1];
			assign res_d   = res_s[k-1];
		end

		always_comb begin
			logic [BoxW:0] trial;
			trial  = '0;
			rem_nx = rem_d;
			dvd_nx = dvd_d;
			for (int a = 0; a < Axes; a++) begin
				for (int j = 0; j < DIV_BITS; j++) begin
					if (k * DIV_BITS + j < BoxW) begin
						trial     = {rem_nx[a], dvd_nx[a][BoxW-1]};
						dvd_nx[a] = {dvd_nx[a][BoxW-2:0], 1'b0};
						if (trial >= {1'b0, box[a]}) begin
							rem_nx[a] = BoxW'(trial - {1'b0, box[a]});
						end else begin
							rem_nx[a] = trial[BoxW-1:0];
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_nx;
				dvd_s[k] <= dvd_nx;
				neg_s[k] <= neg_d;
				res_s[k] <= res_d;
			end
		end
	end

	logic [Axes-1:0][BoxW-1:0] wrapped;
	res_t                      fix_d;
	logic                      valid_q;
	res_t                      res_q;

	always_comb begin
		fix_d = res_s[Stages-1];
		for (int a = 0; a < Axes; a++) begin
			if (box[a] == '0) begin
				wrapped[a] = '0;
			end else if (neg_s[Stages-1][a]) begin
				wrapped[a] = box[a] - rem_s[Stages-1][a] - BoxW'(1);
			end else begin
				wrapped[a] = rem_s[Stages-1][a];
			end
			if (res_s[Stages-1].wrap) begin
				fix_d.pos[a] = {1'b0, wrapped[a]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s[Stages-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fix_d;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

/* rtl/core/particle_leapfrog_push_core.sv */
// ----------------------------------------------------------------------------
// particle_leapfrog_push_core
// Leapfrog push with electric kick, scatter request and box handling.
//
//   channel       dir   handshake       carries
//   particle_in   in    valid / ready   position, velocity, field, draw, empty
//   result_out    out   valid / ready   new position, velocity, outcome, scatter
//   cfg           in    valid / ready   register index and write data
//
// One particle per cycle while particle_in.ready is high; each passes the
// kick, drift and wrap pipelines, then the output register.
// arst_n clears all valid bits and loads the register defaults.
// The pipeline moves as a whole; a one-entry skid buffer in front of the
// output register keeps ready on particle_in a registered signal.
// ----------------------------------------------------------------------------
module particle_leapfrog_push_core import plp_pkg::*; #(
	parameter int DIV_BITS = DivBitsPerStage
) (
	input  logic clk,
	input  logic arst_n,
	plp_particle_if.sink   particle_in,
	plp_result_if.source   result_out,
	plp_cfg_if.sink        cfg
);

	cfg_t  regs;
	logic  en;
	item_t in_item;
	logic [Axes-1:0][QW-1:0] field;

	logic  kick_valid, drift_valid, wrap_valid;
	item_t kick_item;
	res_t  drift_res, wrap_res;

	logic  out_valid_q, skid_valid_q;
	res_t  out_res_q, skid_res_q;
	logic  push;

	plp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// whole pipeline halts only once the skid entry is taken
	assign en                = !skid_valid_q;
	assign particle_in.ready = en;

	assign in_item.pos   = {particle_in.pos_z, particle_in.pos_y, particle_in.pos_x};
	assign in_item.vel   = {particle_in.vel_z, particle_in.vel_y, particle_in.vel_x};
	assign in_item.empty = particle_in.slot_empty;
	assign in_item.draw  = particle_in.random_draw;
	assign field         = {particle_in.field_z, particle_in.field_y, particle_in.field_x};

	plp_kick u_kick (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.half_accel (regs.half_accel),
		.in_valid   (particle_in.valid),
		.in_item    (in_item),
		.field      (field),
		.out_valid  (kick_valid),
		.out_item   (kick_item)
	);

	plp_drift u_drift (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.regs      (regs),
		.in_valid  (kick_valid),
		.in_item   (kick_item),
		.out_valid (drift_valid),
		.out_res   (drift_res)
	);

	plp_wrap #(
		.DIV_BITS (DIV_BITS)
	) u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.box       (regs.box),
		.in_valid  (drift_valid),
		.in_res    (drift_res),
		.out_valid (wrap_valid),
		.out_res   (wrap_res)
	);

	assign push = en && wrap_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result_out.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result_out.ready) begin
			out_res_q <= skid_valid_q ? skid_res_q : wrap_res;
		end else if (push) begin
			skid_res_q <= wrap_res;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.new_x           = out_res_q.pos[0];
	assign result_out.new_y           = out_res_q.pos[1];
	assign result_out.new_z           = out_res_q.pos[2];
	assign result_out.new_vx          = out_res_q.vel[0];
	assign result_out.new_vy          = out_res_q.vel[1];
	assign result_out.new_vz          = out_res_q.vel[2];
	assign result_out.outcome         = out_res_q.outcome;
	assign result_out.scatter_request = out_res_q.scatter;

endmodule
